// ----- rtl/core/bblp_pkg.sv -----
// Shared constants and types of the busy bucket load predictor.
`default_nettype none

package bblp_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned BUCKET_COUNT_DEF  = 10;
  localparam int unsigned HISTORY_DEPTH_DEF = 5;

  // Field and datapath widths.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned BIDX_W = 4;
  localparam int unsigned OPA_W  = 33;
  localparam int unsigned OPB_W  = 5;
  localparam int unsigned PROD_W = OPA_W + OPB_W;

  // Constant divider: dividend width and quotient bits retired per cycle.
  localparam int unsigned DIV_W    = 40;
  localparam int unsigned DIV_STEP = 4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUNTIME    = 2'd2;

  localparam logic [WORD_W-1:0] WINDOW_SIZE_RST = 32'd16000000;
  localparam logic [WORD_W-1:0] MAX_RUNTIME_RST = 32'd16000000;

  // Bucket count update steps.
  localparam logic [CNT_W-1:0] CNT_STEP_UP         = 8'd8;
  localparam logic [CNT_W-1:0] CNT_STEP_UP_FAST    = 8'd16;
  localparam logic [CNT_W-1:0] CNT_STEADY_LVL      = 8'd16;
  localparam logic [CNT_W-1:0] CNT_STEP_DOWN       = 8'd2;
  localparam logic [CNT_W-1:0] CNT_STEP_DOWN_FIRST = 8'd1;
  localparam logic [CNT_W-1:0] CNT_MAX             = 8'd255;

  typedef struct packed {
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/bblp_mul.sv -----
// Shared multiplier of the predictor: one small-by-wide product per cycle, registered.
`default_nettype none

module bblp_mul (
  input  logic                            clk_i,
  input  bblp_pkg::mul_req_t              req_i,
  output logic [bblp_pkg::PROD_W-1:0]     prod_o
);

  localparam int unsigned PW = bblp_pkg::PROD_W;

  logic [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(req_i.a) * PW'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/core/bblp_cdiv.sv -----
// Restoring divider by a constant, retiring a few quotient bits per cycle.
`default_nettype none

module bblp_cdiv #(
  parameter int unsigned DIVISOR = bblp_pkg::BUCKET_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bblp_pkg::div_req_t req_i,
  output bblp_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW    = bblp_pkg::DIV_W;
  localparam int unsigned SW    = bblp_pkg::DIV_STEP;
  localparam int unsigned NSTEP = DW / SW;
  localparam int unsigned CW    = $clog2(NSTEP + 1);
  localparam int unsigned RW    = $clog2(DIVISOR);
  localparam int unsigned TW    = RW + 1;
  localparam logic [TW-1:0] DIV_T = TW'(DIVISOR);

  logic [DW-1:0] num_q, num_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;

  always_comb begin
    logic [TW-1:0] trial;
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    for (int s = 0; s < SW; s++) begin
      trial = {rem_d, num_d[DW-1]};
      num_d = {num_d[DW-2:0], 1'b0};
      if (trial >= DIV_T) begin
        trial = trial - DIV_T;
        quo_d = {quo_d[DW-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[DW-2:0], 1'b0};
      end
      rem_d = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NSTEP);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      quo_q <= '0;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= num_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[bblp_pkg::WORD_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/busy_bucket_load_predictor_unit.sv -----
// Top level of the busy bucket load predictor: sequencer, stores and result port.
//
//   channel   handshake                 payload
//   -------   -----------------------   ----------------------------------------------
//   command   start / busy              runtime_i, window_rollover_i, new_task_i
//   result    done_o (one-cycle pulse)  prediction_o, prediction_changed_o,
//                                       prediction_delta_o, bucket_index_o
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A beat that leaves the state untouched goes from the idle state straight to S_FIN. In a full
// prediction every product goes through the one registered multiplier (a multiply state and
// a compare state per bucket edge test and per history entry), the bucket scan and count
// update visit one bucket per cycle, and a bin midpoint costs two passes of the
// 4-bit-per-cycle constant divider.
// Reset clears the bucket counts, history and prediction at once; no clearing pass.
// The receiver cannot stall results; busy stays high until the result beat is out.
`default_nettype none

module busy_bucket_load_predictor_unit #(
  parameter int unsigned BUCKET_COUNT  = bblp_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned HISTORY_DEPTH = bblp_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bblp_pkg::WORD_W-1:0]          runtime_i,
  input  logic                                 window_rollover_i,
  input  logic                                 new_task_i,
  output logic                                 done_o,
  output logic [bblp_pkg::WORD_W-1:0]          prediction_o,
  output logic                                 prediction_changed_o,
  output logic signed [bblp_pkg::WORD_W:0]     prediction_delta_o,
  output logic [bblp_pkg::BIDX_W-1:0]          bucket_index_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bblp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bblp_pkg::WORD_W-1:0]          cfg_data_i
);

  localparam int unsigned WW  = bblp_pkg::WORD_W;
  localparam int unsigned CW  = bblp_pkg::CNT_W;
  localparam int unsigned PW  = bblp_pkg::PROD_W;
  localparam int unsigned AW  = bblp_pkg::OPA_W;
  localparam int unsigned BW  = bblp_pkg::OPB_W;
  localparam int unsigned DW  = bblp_pkg::DIV_W;
  localparam int unsigned BIW = $clog2(BUCKET_COUNT);
  localparam int unsigned SCW = BIW + 1;
  localparam int unsigned HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam logic [BW-1:0]  BC_B   = BW'(BUCKET_COUNT);
  localparam logic [SCW-1:0] BC_SC  = SCW'(BUCKET_COUNT);
  localparam logic [SCW-1:0] LAST_K = SCW'(BUCKET_COUNT - 1);
  localparam logic [BIW-1:0] LAST_B = BIW'(BUCKET_COUNT - 1);
  localparam logic [HIW-1:0] LAST_H = HIW'(HISTORY_DEPTH - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RTBC    = 5'd1;
  localparam logic [4:0] S_MAP_MUL = 5'd2;
  localparam logic [4:0] S_MAP_CMP = 5'd3;
  localparam logic [4:0] S_SCAN    = 5'd4;
  localparam logic [4:0] S_LO_MUL  = 5'd5;
  localparam logic [4:0] S_HI_MUL  = 5'd6;
  localparam logic [4:0] S_HI_SAV  = 5'd7;
  localparam logic [4:0] S_H_MUL   = 5'd8;
  localparam logic [4:0] S_H_CMP   = 5'd9;
  localparam logic [4:0] S_RT_MUL  = 5'd10;
  localparam logic [4:0] S_RT_CMP  = 5'd11;
  localparam logic [4:0] S_DIV_LO  = 5'd12;
  localparam logic [4:0] S_DIV_HI  = 5'd13;
  localparam logic [4:0] S_CLAMP   = 5'd14;
  localparam logic [4:0] S_UPD     = 5'd15;
  localparam logic [4:0] S_FIN     = 5'd16;

  function automatic logic [CW-1:0] cnt_hit(input logic [CW-1:0] b);
    logic [CW-1:0] inc;
    inc = (b >= bblp_pkg::CNT_STEADY_LVL) ? bblp_pkg::CNT_STEP_UP_FAST : bblp_pkg::CNT_STEP_UP;
    cnt_hit = (b > (bblp_pkg::CNT_MAX - inc)) ? bblp_pkg::CNT_MAX : b + inc;
  endfunction

  function automatic logic [CW-1:0] cnt_decay(input logic [CW-1:0] b, input logic big);
    logic [CW-1:0] dec;
    dec = big ? bblp_pkg::CNT_STEP_DOWN : bblp_pkg::CNT_STEP_DOWN_FIRST;
    cnt_decay = (b > dec) ? b - dec : '0;
  endfunction

  logic [4:0]     st_q;
  logic [WW-1:0]  win_q;
  logic           en_q;
  logic [WW-1:0]  max_q;
  logic [CW-1:0]  cnt_q [BUCKET_COUNT];
  logic [WW-1:0]  hist_q [HISTORY_DEPTH];
  logic [WW-1:0]  pred_q;

  logic [WW-1:0]  rt_q;
  logic           roll_q;
  logic           new_q;
  logic [WW-1:0]  old_q;
  logic [WW-1:0]  newp_q;
  logic [WW-1:0]  ret_q;
  logic           chg_q;
  logic [BIW-1:0] bidx_q;
  logic [SCW-1:0] k_q;
  logic [BIW-1:0] pick_q;
  logic [HIW-1:0] j_q;
  logic [BIW-1:0] ui_q;
  logic           dec2_q;
  logic [PW-1:0]  rtbc_q;
  logic [PW-1:0]  xlo_q;
  logic [PW-1:0]  xhi_q;
  logic [WW-1:0]  dlo_q;

  logic                done_q;
  logic [WW-1:0]       out_pred_q;
  logic                out_chg_q;
  logic signed [WW:0]  out_delta_q;
  logic [BIW-1:0]      out_bidx_q;

  bblp_pkg::mul_req_t mul_req;
  logic [PW-1:0]      prod;
  bblp_pkg::div_req_t div_req;
  bblp_pkg::div_rsp_t div_rsp;

  logic           map_pass;
  logic [BIW-1:0] map_cnt;
  logic [BIW-1:0] map_final;
  logic [CW-1:0]  cnt_sel;
  logic [CW-1:0]  upd_sel;
  logic [WW-1:0]  hist_sel;
  logic           h_hit;
  logic [WW:0]    mid_sum;
  logic [WW-1:0]  clamp_val;
  logic [BW-1:0]  pick_lo;
  logic [BW-1:0]  pick_hi;

  assign busy        = (st_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign hist_sel  = hist_q[j_q];
  assign cnt_sel   = cnt_q[k_q[BIW-1:0]];
  assign upd_sel   = cnt_q[ui_q];
  assign map_pass  = (prod <= rtbc_q);
  assign map_cnt   = map_pass ? k_q[BIW-1:0] : bidx_q;
  assign map_final = (map_cnt == '0) ? BIW'(1) : map_cnt;
  assign h_hit     = (xlo_q < prod) && (prod <= xhi_q);
  assign mid_sum   = {1'b0, dlo_q} + {1'b0, div_rsp.quotient};
  assign clamp_val = (ret_q > max_q) ? max_q : ret_q;

  // The two lowest buckets share one range that starts at zero.
  assign pick_lo = (pick_q < BIW'(2)) ? '0 : BW'(pick_q);
  assign pick_hi = (pick_q < BIW'(2)) ? BW'(2) : BW'(pick_q) + BW'(1);

  // Bucket edges are never divided out for the range tests: h lies in
  // [floor(X/N), floor(Y/N)) exactly when X < (h+1)*N <= Y.
  always_comb begin
    mul_req = '0;
    case (st_q)
      S_RTBC: begin
        mul_req.a = AW'(rt_q);
        mul_req.b = BC_B;
      end
      S_MAP_MUL: begin
        mul_req.a = AW'(win_q);
        mul_req.b = BW'(k_q);
      end
      S_LO_MUL: begin
        mul_req.a = AW'(win_q);
        mul_req.b = pick_lo;
      end
      S_HI_MUL: begin
        mul_req.a = AW'(win_q);
        mul_req.b = pick_hi;
      end
      S_H_MUL: begin
        mul_req.a = AW'(hist_sel) + AW'(1);
        mul_req.b = BC_B;
      end
      S_RT_MUL: begin
        mul_req.a = AW'(rt_q) + AW'(1);
        mul_req.b = BC_B;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = ((st_q == S_RT_CMP) && (prod <= xlo_q)) ||
                       ((st_q == S_DIV_LO) && div_rsp.done);
    div_req.dividend = (st_q == S_RT_CMP) ? DW'(xlo_q) : DW'(xhi_q);
  end

  bblp_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  bblp_cdiv #(
    .DIVISOR (BUCKET_COUNT)
  ) u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      win_q       <= bblp_pkg::WINDOW_SIZE_RST;
      en_q        <= 1'b0;
      max_q       <= bblp_pkg::MAX_RUNTIME_RST;
      for (int i = 0; i < BUCKET_COUNT; i++) cnt_q[i] <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
      pred_q      <= '0;
      rt_q        <= '0;
      roll_q      <= 1'b0;
      new_q       <= 1'b0;
      old_q       <= '0;
      newp_q      <= '0;
      ret_q       <= '0;
      chg_q       <= 1'b0;
      bidx_q      <= '0;
      k_q         <= '0;
      pick_q      <= '0;
      j_q         <= '0;
      ui_q        <= '0;
      dec2_q      <= 1'b0;
      rtbc_q      <= '0;
      xlo_q       <= '0;
      xhi_q       <= '0;
      dlo_q       <= '0;
      done_q      <= 1'b0;
      out_pred_q  <= '0;
      out_chg_q   <= 1'b0;
      out_delta_q <= '0;
      out_bidx_q  <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bblp_pkg::REG_WINDOW_SIZE:    win_q <= cfg_data_i;
          bblp_pkg::REG_PREDICT_ENABLE: en_q  <= cfg_data_i[0];
          bblp_pkg::REG_MAX_RUNTIME:    max_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (st_q)
        S_IDLE: begin
          if (start) begin
            rt_q   <= runtime_i;
            roll_q <= window_rollover_i;
            new_q  <= new_task_i;
            old_q  <= pred_q;
            if (!window_rollover_i && ((runtime_i <= pred_q) || !en_q)) begin
              newp_q <= pred_q;
              chg_q  <= 1'b0;
              bidx_q <= '0;
              st_q   <= S_FIN;
            end else begin
              chg_q <= 1'b1;
              if (window_rollover_i) begin
                hist_q[0] <= runtime_i;
                for (int i = 1; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i-1];
              end
              if (!en_q) begin
                bidx_q <= BIW'(1);
                ret_q  <= runtime_i;
                st_q   <= S_CLAMP;
              end else begin
                st_q <= S_RTBC;
              end
            end
          end
        end
        S_RTBC: begin
          k_q    <= SCW'(1);
          bidx_q <= '0;
          st_q   <= S_MAP_MUL;
        end
        S_MAP_MUL: begin
          // On the first pass the product register still holds runtime * N.
          if (k_q == SCW'(1)) rtbc_q <= prod;
          st_q <= S_MAP_CMP;
        end
        S_MAP_CMP: begin
          if (map_pass && (k_q != LAST_K)) begin
            bidx_q <= k_q[BIW-1:0];
            k_q    <= k_q + SCW'(1);
            st_q   <= S_MAP_MUL;
          end else begin
            bidx_q <= map_final;
            k_q    <= SCW'(map_final);
            if (new_q) begin
              ret_q <= rt_q;
              st_q  <= S_CLAMP;
            end else begin
              st_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (k_q == BC_SC) begin
            ret_q <= rt_q;
            st_q  <= S_CLAMP;
          end else if (cnt_sel != '0) begin
            pick_q <= k_q[BIW-1:0];
            st_q   <= S_LO_MUL;
          end else begin
            k_q <= k_q + SCW'(1);
          end
        end
        S_LO_MUL: begin
          st_q <= S_HI_MUL;
        end
        S_HI_MUL: begin
          xlo_q <= prod;
          st_q  <= S_HI_SAV;
        end
        S_HI_SAV: begin
          xhi_q <= prod;
          j_q   <= '0;
          st_q  <= S_H_MUL;
        end
        S_H_MUL: begin
          st_q <= S_H_CMP;
        end
        S_H_CMP: begin
          if (h_hit) begin
            ret_q <= (hist_sel < rt_q) ? rt_q : hist_sel;
            st_q  <= S_CLAMP;
          end else if (j_q == LAST_H) begin
            st_q <= S_RT_MUL;
          end else begin
            j_q  <= j_q + HIW'(1);
            st_q <= S_H_MUL;
          end
        end
        S_RT_MUL: begin
          st_q <= S_RT_CMP;
        end
        S_RT_CMP: begin
          // Runtime below the range start: fall back to the bin midpoint.
          if (prod <= xlo_q) begin
            st_q <= S_DIV_LO;
          end else begin
            ret_q <= rt_q;
            st_q  <= S_CLAMP;
          end
        end
        S_DIV_LO: begin
          if (div_rsp.done) begin
            dlo_q <= div_rsp.quotient;
            st_q  <= S_DIV_HI;
          end
        end
        S_DIV_HI: begin
          if (div_rsp.done) begin
            ret_q <= mid_sum[WW:1];
            st_q  <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          newp_q <= clamp_val;
          if (roll_q && en_q) begin
            ui_q   <= LAST_B;
            dec2_q <= 1'b0;
            st_q   <= S_UPD;
          end else begin
            st_q <= S_FIN;
          end
        end
        S_UPD: begin
          // Walk from the top bucket down; the first decayed bucket loses less.
          if (ui_q == bidx_q) begin
            cnt_q[ui_q] <= cnt_hit(upd_sel);
          end else if (upd_sel != '0) begin
            cnt_q[ui_q] <= cnt_decay(upd_sel, dec2_q);
            dec2_q      <= 1'b1;
          end
          if (ui_q == '0) begin
            st_q <= S_FIN;
          end else begin
            ui_q <= ui_q - BIW'(1);
          end
        end
        S_FIN: begin
          pred_q      <= newp_q;
          done_q      <= 1'b1;
          out_pred_q  <= newp_q;
          out_chg_q   <= chg_q;
          out_delta_q <= $signed({1'b0, newp_q}) - $signed({1'b0, old_q});
          out_bidx_q  <= bidx_q;
          st_q        <= S_IDLE;
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o               = done_q;
  assign prediction_o         = out_pred_q;
  assign prediction_changed_o = out_chg_q;
  assign prediction_delta_o   = out_delta_q;
  assign bucket_index_o       = bblp_pkg::BIDX_W'(out_bidx_q);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result beat not at the end of a busy period");

  a_pred_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && prediction_changed_o) |-> (prediction_o <= max_q))
    else $error("stored prediction above max runtime");

  a_div_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((st_q == S_DIV_LO) || (st_q == S_DIV_HI)))
    else $error("divider finished outside a midpoint step");

endmodule

`default_nettype wire

// ----- verif/tb_busy_bucket_load_predictor_unit.sv -----
// Self-checking testbench for busy_bucket_load_predictor_unit with its own prediction of each beat.
module tb_busy_bucket_load_predictor_unit;

  localparam int unsigned WORD_W      = bblp_pkg::WORD_W;
  localparam int unsigned BIDX_W      = bblp_pkg::BIDX_W;
  localparam int unsigned CNT_W       = bblp_pkg::CNT_W;
  localparam int unsigned CFG_IDX_W   = bblp_pkg::CFG_IDX_W;
  localparam int unsigned NBKT        = bblp_pkg::BUCKET_COUNT_DEF;
  localparam int unsigned NHIST       = bblp_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [WORD_W-1:0] rt;
    logic              roll;
    logic              newt;
    logic              hold;  // wait for all outstanding results before this beat
  } beat_t;

  typedef struct {
    logic [WORD_W-1:0]        prediction;
    logic                     changed;
    logic signed [WORD_W:0]   delta;
    logic [BIDX_W-1:0]        bidx;
  } forecast_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [WORD_W-1:0]      runtime_i = '0;
  logic                   window_rollover_i = 1'b0;
  logic                   new_task_i = 1'b0;
  logic                   done_o;
  logic [WORD_W-1:0]      prediction_o;
  logic                   prediction_changed_o;
  logic signed [WORD_W:0] prediction_delta_o;
  logic [BIDX_W-1:0]      bucket_index_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [WORD_W-1:0]      cfg_data_i = '0;

  // Predictor copy of the configuration and the state.
  logic [WORD_W-1:0] win_size = bblp_pkg::WINDOW_SIZE_RST;
  logic              pred_en  = 1'b0;
  logic [WORD_W-1:0] max_rt   = bblp_pkg::MAX_RUNTIME_RST;
  logic [CNT_W-1:0]  bkt_cnt [NBKT];
  logic [WORD_W-1:0] rt_hist [NHIST];
  logic [WORD_W-1:0] cur_pred = '0;

  beat_t     runtime_q [$];
  forecast_t forecast_q [$];
  int        err_cnt = 0;
  int        burst_left = 1;
  int        gap_left = 0;

  busy_bucket_load_predictor_unit uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .runtime_i            (runtime_i),
    .window_rollover_i    (window_rollover_i),
    .new_task_i           (new_task_i),
    .done_o               (done_o),
    .prediction_o         (prediction_o),
    .prediction_changed_o (prediction_changed_o),
    .prediction_delta_o   (prediction_delta_o),
    .bucket_index_o       (bucket_index_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic logic [63:0] bkt_edge(input int unsigned k);
    return (64'(k) * 64'(win_size)) / 64'(NBKT);
  endfunction

  function automatic logic [BIDX_W-1:0] map_to_bucket(input logic [WORD_W-1:0] rt);
    logic [63:0] q;
    if (!pred_en) return 4'd1;
    // A zero window divides to all ones, which lands in the top bucket.
    if (win_size == '0) q = '1;
    else q = (64'(rt) * 64'(NBKT)) / 64'(win_size);
    if (q > 64'(NBKT - 1)) q = 64'(NBKT - 1);
    if (q == 64'd0) q = 64'd1;
    return q[BIDX_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] pick_prediction(input int unsigned from_bkt,
                                                        input logic [WORD_W-1:0] rt,
                                                        input logic newt);
    logic [63:0] ret;
    logic [63:0] dmin;
    logic [63:0] dmax;
    int unsigned pick;
    logic found;
    ret = 64'(rt);
    pick = NBKT;
    if (pred_en && !newt) begin
      for (int unsigned i = from_bkt; i < NBKT; i++) begin
        if (pick == NBKT && bkt_cnt[i] != '0) pick = i;
      end
      if (pick < NBKT) begin
        if (pick < 2) begin
          dmin = '0;
          pick = 1;
        end else begin
          dmin = bkt_edge(pick);
        end
        dmax = bkt_edge(pick + 1);
        found = 1'b0;
        for (int i = 0; i < NHIST; i++) begin
          if (!found && 64'(rt_hist[i]) >= dmin && 64'(rt_hist[i]) < dmax) begin
            ret = 64'(rt_hist[i]);
            found = 1'b1;
          end
        end
        if (ret < dmin) ret = (dmin + dmax) / 2;
        if (ret < 64'(rt)) ret = 64'(rt);
      end
    end
    if (ret > 64'(max_rt)) ret = 64'(max_rt);
    return ret[WORD_W-1:0];
  endfunction

  function automatic void age_buckets(input logic [BIDX_W-1:0] hit);
    logic [CNT_W-1:0] dec;
    logic [CNT_W-1:0] inc;
    logic [CNT_W-1:0] b;
    if (!pred_en) return;
    dec = bblp_pkg::CNT_STEP_DOWN_FIRST;
    // Walk from the top: the first non-zero bucket met decays by the small step.
    for (int i = NBKT - 1; i >= 0; i--) begin
      b = bkt_cnt[i];
      if (i != int'(hit)) begin
        if (b != '0) begin
          b = (b > dec) ? b - dec : '0;
          dec = bblp_pkg::CNT_STEP_DOWN;
        end
      end else begin
        inc = (b >= bblp_pkg::CNT_STEADY_LVL) ? bblp_pkg::CNT_STEP_UP_FAST :
                                                bblp_pkg::CNT_STEP_UP;
        b = (b > bblp_pkg::CNT_MAX - inc) ? bblp_pkg::CNT_MAX : b + inc;
      end
      bkt_cnt[i] = b;
    end
  endfunction

  function automatic forecast_t forecast_beat(input logic [WORD_W-1:0] rt, input logic roll,
                                              input logic newt);
    forecast_t f;
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] p;
    logic [BIDX_W-1:0] bi;
    prev = cur_pred;
    if (!roll && (rt <= prev || !pred_en)) begin
      f.prediction = prev;
      f.changed    = 1'b0;
      f.delta      = '0;
      f.bidx       = '0;
      return f;
    end
    if (roll) begin
      for (int i = NHIST - 1; i >= 1; i--) rt_hist[i] = rt_hist[i-1];
      rt_hist[0] = rt;
    end
    bi = map_to_bucket(rt);
    p = pick_prediction(int'(bi), rt, newt);
    if (roll) age_buckets(bi);
    cur_pred = p;
    f.prediction = p;
    f.changed    = 1'b1;
    f.delta      = {1'b0, p} - {1'b0, prev};
    f.bidx       = bi;
    return f;
  endfunction

  function automatic void push_beat(input logic [WORD_W-1:0] rt, input logic roll,
                                    input logic newt, input logic hold);
    beat_t b;
    b.rt   = rt;
    b.roll = roll;
    b.newt = newt;
    b.hold = hold;
    runtime_q.push_back(b);
  endfunction

  function automatic logic [WORD_W-1:0] pick_level();
    logic [63:0] lv;
    if (win_size == '0) return WORD_W'($urandom_range(0, 1000));
    lv = (64'(win_size) * 64'($urandom_range(0, 1100))) / 64'd1000;
    if (lv > 64'hFFFF_FFFF) lv = 64'hFFFF_FFFF;
    return lv[WORD_W-1:0];
  endfunction

  // Mostly whole windows of one task at a steady level, with some noise mixed in.
  task automatic fill_random(input int n);
    logic [63:0] level;
    logic [63:0] jit;
    logic [63:0] total;
    logic        fresh;
    int          left;
    int          hold_at;
    int          wins;
    int          mids;
    left = n;
    hold_at = $urandom_range(n / 4, 3 * n / 4);
    level = 64'(pick_level());
    fresh = 1'b1;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 3))
          0: push_beat($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       left == hold_at);
          1: push_beat('1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       left == hold_at);
          2: push_beat('0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       left == hold_at);
          default: push_beat(WORD_W'(level >> $urandom_range(0, 4)), 1'b0,
                             1'($urandom_range(0, 1)), left == hold_at);
        endcase
        left--;
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          level = 64'(pick_level());
          fresh = 1'b1;
        end
        wins = $urandom_range(1, 6);
        for (int w = 0; w < wins && left > 0; w++) begin
          jit = level >> 5;
          total = level - jit + (64'($urandom) % (2 * jit + 1));
          if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
          mids = $urandom_range(0, 3);
          for (int m = 1; m <= mids && left > 0; m++) begin
            push_beat(WORD_W'(total * m / (mids + 1)), 1'b0, $urandom_range(0, 15) == 0,
                      left == hold_at);
            left--;
          end
          if (left > 0) begin
            push_beat(WORD_W'(total), 1'b1,
                      (fresh && $urandom_range(0, 1) == 1) || $urandom_range(0, 15) == 0,
                      left == hold_at);
            left--;
          end
          fresh = 1'b0;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bblp_pkg::REG_WINDOW_SIZE:    win_size = val;
      bblp_pkg::REG_PREDICT_ENABLE: pred_en  = val[0];
      bblp_pkg::REG_MAX_RUNTIME:    max_rt   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [WORD_W-1:0] w, input logic en,
                            input logic [WORD_W-1:0] m);
    write_reg(bblp_pkg::REG_WINDOW_SIZE, w);
    write_reg(bblp_pkg::REG_PREDICT_ENABLE, {{(WORD_W-1){1'b0}}, en});
    write_reg(bblp_pkg::REG_MAX_RUNTIME, m);
    @(negedge clk_i);
  endtask

  // Sampled on the falling edge so that it never races the clocked blocks.
  task automatic wait_drained;
    do @(negedge clk_i);
    while (runtime_q.size() != 0 || start || busy || forecast_q.size() != 0);
  endtask

  always @(posedge clk_i) begin : drive_beats
    logic      take;
    logic      start_nxt;
    forecast_t f;
    take = start && !busy;
    start_nxt = start;
    if (take) begin
      f = forecast_beat(runtime_i, window_rollover_i, new_task_i);
      forecast_q.push_back(f);
      void'(runtime_q.pop_front());
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end
    end
    if (!start || take) begin
      start_nxt = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (rst_ni && runtime_q.size() != 0 &&
                   (!runtime_q[0].hold ||
                    (!take && !busy && !done_o && forecast_q.size() == 0))) begin
        start_nxt = 1'b1;
        runtime_i         <= runtime_q[0].rt;
        window_rollover_i <= runtime_q[0].roll;
        new_task_i        <= runtime_q[0].newt;
      end
    end
    start <= start_nxt;
  end

  always @(posedge clk_i) begin : check_results
    forecast_t exp_r;
    if (rst_ni && done_o) begin
      if (forecast_q.size() == 0) begin
        log_error("result beat with no prediction outstanding");
      end else begin
        exp_r = forecast_q.pop_front();
        if (prediction_o !== exp_r.prediction || prediction_changed_o !== exp_r.changed ||
            prediction_delta_o !== exp_r.delta || bucket_index_o !== exp_r.bidx) begin
          log_error($sformatf({"expected pred=%0h chg=%0b delta=%0h bkt=%0d, ",
                               "got pred=%0h chg=%0b delta=%0h bkt=%0d"},
                              exp_r.prediction, exp_r.changed, exp_r.delta, exp_r.bidx,
                              prediction_o, prediction_changed_o, prediction_delta_o,
                              bucket_index_o));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("busy_bucket_load_predictor_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [WORD_W-1:0] rnd_w;
    for (int i = 0; i < NBKT; i++) bkt_cnt[i] = '0;
    for (int i = 0; i < NHIST; i++) rt_hist[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: prediction is off, so rollover runtimes pass through clamped and other beats keep the prediction.
    push_beat(32'd5, 1'b0, 1'b0, 1'b0);
    push_beat('0, 1'b1, 1'b0, 1'b0);
    push_beat('1, 1'b1, 1'b0, 1'b0);
    push_beat(32'd1234567, 1'b1, 1'b1, 1'b0);
    push_beat('1, 1'b0, 1'b1, 1'b0);
    wait_drained;

    set_config(32'd16000000, 1'b1, 32'd16000000);
    push_beat(32'd8000000, 1'b1, 1'b0, 1'b0);
    push_beat(32'd8000000, 1'b1, 1'b0, 1'b0);
    // Flush bucket five out of the history, then land below it: midpoint is used.
    repeat (5) push_beat(32'd4000000, 1'b1, 1'b0, 1'b0);
    push_beat(32'd7000000, 1'b0, 1'b0, 1'b0);
    push_beat(32'd1000000, 1'b0, 1'b0, 1'b0);
    push_beat('0, 1'b1, 1'b0, 1'b0);
    push_beat(32'd100, 1'b1, 1'b1, 1'b0);
    push_beat('1, 1'b1, 1'b0, 1'b0);
    push_beat('1, 1'b0, 1'b0, 1'b0);
    wait_drained;

    set_config('0, 1'b1, '1);
    push_beat(32'd5, 1'b1, 1'b0, 1'b0);
    push_beat('1, 1'b0, 1'b0, 1'b1);
    push_beat('1, 1'b1, 1'b0, 1'b0);
    wait_drained;

    set_config('1, 1'b1, '1);
    push_beat('1, 1'b1, 1'b0, 1'b0);
    push_beat(32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0);
    push_beat(32'h8000_0000, 1'b0, 1'b0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained;
      case (ph)
        0: set_config(32'd16000000, 1'b1, 32'd16000000);
        1: set_config(32'd1000, 1'b1, 32'd1000);
        2: set_config('1, 1'b1, '1);
        3: set_config(32'd1, 1'b1, '0);
        4: set_config('0, 1'b1, $urandom);
        5: begin
          rnd_w = $urandom_range(10, 32'h7FFF_FFFF);
          set_config(rnd_w, 1'b1, $urandom_range(0, rnd_w));
        end
        6: set_config($urandom, 1'b0, $urandom);
        default: set_config(32'd16000000, 1'b1, 32'd12000000);
      endcase
      fill_random(190);
    end

    wait_drained;
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && forecast_q.size() == 0) begin
      $display("busy_bucket_load_predictor_unit regression: pass");
    end else begin
      $display("busy_bucket_load_predictor_unit regression: fail");
    end
    $finish;
  end

endmodule
